// ===== design/abams_pkg.sv =====
`default_nettype none

package abams_pkg;

  localparam int SETS_PER_BLOCK = 32;
  localparam int SETS_LOG2      = $clog2(SETS_PER_BLOCK);
  localparam int CNT_W          = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = SAMPLE_W + SETS_LOG2;
  localparam int MV_W     = 13;
  localparam int HEIGHT_W = 8;
  localparam int CHAR_W   = 6;
  localparam int DIGIT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int PROD_W    = SUM_W + MV_W;
  localparam int DIV_NUM_W = MV_W + HEIGHT_W;
  localparam int DIV_DEN_W = MV_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

  localparam logic [MV_W-1:0]     REFERENCE_RESET = 13'd3300;
  localparam logic [MV_W-1:0]     PLOT_LOW_RESET  = 13'd1500;
  localparam logic [MV_W-1:0]     PLOT_HIGH_RESET = 13'd2000;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 8'd150;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/abams_divider.sv =====
`default_nettype none

module abams_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire abams_pkg::div_req_t req,
  output abams_pkg::div_rsp_t      rsp
);

  localparam int NUM_W = abams_pkg::DIV_NUM_W;
  localparam int DEN_W = abams_pkg::DIV_DEN_W;
  localparam int CW    = abams_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] LAST_STEP = CW'(NUM_W - 1);

  logic             busy;
  logic             done;
  logic [CW-1:0]    step;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !req.start && busy && (step == LAST_STEP);
      if (req.start) begin
        busy    <= 1'b1;
        step    <= '0;
        quo     <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], fits};
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ===== design/adc_block_average_millivolt_scaler_top.sv =====
// three-channel adc block averager with millivolt scaling
//
// input channel: in_valid/in_ready with sample_ch0..2, one sample set per item.
// each set is added into three accumulators when it is taken; in_ready stays
// high afterwards except after the last set of a block.
// after the 32nd set of a block the block computes one result and holds
// in_ready low meanwhile: three products on a shared 17x13 multiplier, one
// product for the plot scale, then three or four divisions on a shared
// one-bit-per-cycle divider (plot scale only when channel 2 lies between the
// plot levels, then thousands, hundreds, tens); out_valid rises once the last
// division is done and the output register is free.
// output channel: out_valid/out_ready from an output register. a result waits
// there until taken while new sets are accumulated; if the next result is
// ready before the old one is taken, the block waits with in_ready low.
// config: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; the user must
// write only while the block is idle, unchecked; block-end values are used.
// reset: accumulators and set count clear, registers take their defaults
// (3300 mv reference, 1500/2000 mv plot levels, height 150), no result pending.

`default_nettype none

module adc_block_average_millivolt_scaler_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,

  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [abams_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [abams_pkg::CFG_DATA_W-1:0]      cfg_data,

  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [abams_pkg::SAMPLE_W-1:0]        sample_ch0,
  input  wire logic [abams_pkg::SAMPLE_W-1:0]        sample_ch1,
  input  wire logic [abams_pkg::SAMPLE_W-1:0]        sample_ch2,

  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [abams_pkg::MV_W-1:0]                 avg_mv_ch0,
  output logic [abams_pkg::MV_W-1:0]                 avg_mv_ch1,
  output logic [abams_pkg::MV_W-1:0]                 avg_mv_ch2,
  output logic [abams_pkg::CHAR_W-1:0]               thousands_char,
  output logic [abams_pkg::CHAR_W-1:0]               hundreds_char,
  output logic [abams_pkg::CHAR_W-1:0]               tens_char,
  output logic [abams_pkg::CHAR_W-1:0]               ones_char,
  output logic [abams_pkg::HEIGHT_W-1:0]             plot_value
);

  localparam int SUM_W  = abams_pkg::SUM_W;
  localparam int MV_W   = abams_pkg::MV_W;
  localparam int HT_W   = abams_pkg::HEIGHT_W;
  localparam int PROD_W = abams_pkg::PROD_W;
  localparam int CNT_W  = abams_pkg::CNT_W;
  localparam int DG_W   = abams_pkg::DIGIT_W;
  localparam int REM_W  = 10;

  localparam logic [CNT_W-1:0] LAST_SET = CNT_W'(abams_pkg::SETS_PER_BLOCK - 1);

  localparam logic [3:0] S_ACC    = 4'd0;
  localparam logic [3:0] S_MUL0   = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_MUL3   = 4'd4;
  localparam logic [3:0] S_PMUL   = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [1:0] DIV_PLOT = 2'd0;
  localparam logic [1:0] DIV_THOU = 2'd1;
  localparam logic [1:0] DIV_HUND = 2'd2;
  localparam logic [1:0] DIV_TENS = 2'd3;

  localparam logic [MV_W-1:0] DEC_1000 = 13'd1000;
  localparam logic [MV_W-1:0] DEC_100  = 13'd100;
  localparam logic [MV_W-1:0] DEC_10   = 13'd10;

  logic [MV_W-1:0]  reference_mv;
  logic [MV_W-1:0]  plot_low_mv;
  logic [MV_W-1:0]  plot_high_mv;
  logic [HT_W-1:0]  plot_height;

  logic [3:0]       state;
  logic [1:0]       div_op;
  logic [CNT_W-1:0] sets_taken;
  logic [SUM_W-1:0] sum_ch0;
  logic [SUM_W-1:0] sum_ch1;
  logic [SUM_W-1:0] sum_ch2;

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  mul_a;
  logic [MV_W-1:0]   mul_b;

  logic [MV_W-1:0]   mv0;
  logic [MV_W-1:0]   mv1;
  logic [MV_W-1:0]   mv2;
  logic [HT_W-1:0]   plot;
  logic [DG_W-1:0]   thou;
  logic [DG_W-1:0]   hund;
  logic [DG_W-1:0]   tens;
  logic [DG_W-1:0]   ones;
  logic [REM_W-1:0]  rem;

  logic [MV_W-1:0]   mv2_above_low;
  logic              out_load;

  abams_pkg::div_req_t div_req;
  abams_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_ACC);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mv <= abams_pkg::REFERENCE_RESET;
      plot_low_mv  <= abams_pkg::PLOT_LOW_RESET;
      plot_high_mv <= abams_pkg::PLOT_HIGH_RESET;
      plot_height  <= abams_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abams_pkg::REG_REFERENCE: reference_mv <= cfg_data[MV_W-1:0];
        abams_pkg::REG_PLOT_LOW:  plot_low_mv  <= cfg_data[MV_W-1:0];
        abams_pkg::REG_PLOT_HIGH: plot_high_mv <= cfg_data[MV_W-1:0];
        abams_pkg::REG_HEIGHT:    plot_height  <= cfg_data[HT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // shared multiplier operand select
  assign mv2_above_low = mv2 - plot_low_mv;

  always_comb begin
    case (state)
      S_MUL0: begin
        mul_a = sum_ch0;
        mul_b = reference_mv;
      end
      S_MUL1: begin
        mul_a = sum_ch1;
        mul_b = reference_mv;
      end
      S_MUL2: begin
        mul_a = sum_ch2;
        mul_b = reference_mv;
      end
      default: begin
        mul_a = SUM_W'(mv2_above_low);
        mul_b = MV_W'(plot_height);
      end
    endcase
  end

  // shared divider operand select
  always_comb begin
    div_req.start = (state == S_DSTART);
    case (div_op)
      DIV_PLOT: begin
        div_req.dividend = prod[abams_pkg::DIV_NUM_W-1:0];
        div_req.divisor  = plot_high_mv - plot_low_mv;
      end
      DIV_THOU: begin
        div_req.dividend = abams_pkg::DIV_NUM_W'(mv2);
        div_req.divisor  = DEC_1000;
      end
      DIV_HUND: begin
        div_req.dividend = abams_pkg::DIV_NUM_W'(rem);
        div_req.divisor  = DEC_100;
      end
      default: begin
        div_req.dividend = abams_pkg::DIV_NUM_W'(rem);
        div_req.divisor  = DEC_10;
      end
    endcase
  end

  abams_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (state == S_MUL0 || state == S_MUL1 || state == S_MUL2 || state == S_PMUL) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_ACC;
      div_op     <= DIV_PLOT;
      sets_taken <= '0;
      sum_ch0    <= '0;
      sum_ch1    <= '0;
      sum_ch2    <= '0;
    end else begin
      case (state)
        S_ACC: begin
          if (in_valid) begin
            sum_ch0 <= sum_ch0 + SUM_W'(sample_ch0);
            sum_ch1 <= sum_ch1 + SUM_W'(sample_ch1);
            sum_ch2 <= sum_ch2 + SUM_W'(sample_ch2);
            if (sets_taken == LAST_SET) begin
              sets_taken <= '0;
              state      <= S_MUL0;
            end else begin
              sets_taken <= sets_taken + 1'b1;
            end
          end
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: begin
          mv0   <= prod[SUM_W +: MV_W];
          state <= S_MUL2;
        end
        S_MUL2: begin
          mv1   <= prod[SUM_W +: MV_W];
          state <= S_MUL3;
        end
        S_MUL3: begin
          mv2     <= prod[SUM_W +: MV_W];
          sum_ch0 <= '0;
          sum_ch1 <= '0;
          sum_ch2 <= '0;
          state   <= S_PMUL;
        end
        S_PMUL: begin
          // clamp ends need no division; the product is taken anyway
          if (mv2 <= plot_low_mv) begin
            plot   <= '0;
            div_op <= DIV_THOU;
          end else if (mv2 >= plot_high_mv) begin
            plot   <= plot_height;
            div_op <= DIV_THOU;
          end else begin
            div_op <= DIV_PLOT;
          end
          state <= S_DSTART;
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            case (div_op)
              DIV_PLOT: begin
                plot   <= div_rsp.quotient[HT_W-1:0];
                div_op <= DIV_THOU;
                state  <= S_DSTART;
              end
              DIV_THOU: begin
                thou   <= div_rsp.quotient[DG_W-1:0];
                rem    <= div_rsp.remainder[REM_W-1:0];
                div_op <= DIV_HUND;
                state  <= S_DSTART;
              end
              DIV_HUND: begin
                hund   <= div_rsp.quotient[DG_W-1:0];
                rem    <= div_rsp.remainder[REM_W-1:0];
                div_op <= DIV_TENS;
                state  <= S_DSTART;
              end
              default: begin
                tens  <= div_rsp.quotient[DG_W-1:0];
                ones  <= div_rsp.remainder[DG_W-1:0];
                state <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_mv_ch0     <= mv0;
      avg_mv_ch1     <= mv1;
      avg_mv_ch2     <= mv2;
      thousands_char <= abams_pkg::ASCII_ZERO + abams_pkg::CHAR_W'(thou);
      hundreds_char  <= abams_pkg::ASCII_ZERO + abams_pkg::CHAR_W'(hund);
      tens_char      <= abams_pkg::ASCII_ZERO + abams_pkg::CHAR_W'(tens);
      ones_char      <= abams_pkg::ASCII_ZERO + abams_pkg::CHAR_W'(ones);
      plot_value     <= plot;
    end
  end

endmodule

`default_nettype wire

// ===== design/abams_checker.sv =====
`default_nettype none

module abams_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic [abams_pkg::MV_W-1:0]        avg_mv_ch2,
  input  wire logic [abams_pkg::CHAR_W-1:0]      thousands_char,
  input  wire logic [abams_pkg::CHAR_W-1:0]      hundreds_char,
  input  wire logic [abams_pkg::CHAR_W-1:0]      tens_char,
  input  wire logic [abams_pkg::CHAR_W-1:0]      ones_char,
  input  wire logic [abams_pkg::HEIGHT_W-1:0]    plot_value
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(avg_mv_ch2) && $stable(plot_value))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hundreds_char >= 6'd48 && hundreds_char <= 6'd57 &&
                   tens_char >= 6'd48 && tens_char <= 6'd57 &&
                   ones_char >= 6'd48 && ones_char <= 6'd57))
    else $error("digit character out of range");

  // the four digits spell channel 2's millivolts
  a_digits_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(avg_mv_ch2) ==
      (32'(thousands_char) - 32'd48) * 32'd1000 + (32'(hundreds_char) - 32'd48) * 32'd100 +
      (32'(tens_char) - 32'd48) * 32'd10 + (32'(ones_char) - 32'd48)))
    else $error("digits disagree with channel 2 average");

endmodule

bind adc_block_average_millivolt_scaler_top abams_checker u_abams_checker (.*);

`default_nettype wire
